// ===== rtl/core/svfd_pkg.sv =====
package svfd_pkg;

    // Frame format: header length in sync bytes and the largest frame size.
    localparam int HEADER_LEN = 2;
    localparam int MAX_SERVOS = 64;

    // The slot field is 6 bits wide, so a frame never holds more than 64 records.
    localparam int SLOT_LIMIT = 64;
    localparam int COUNT_LIMIT = (MAX_SERVOS < SLOT_LIMIT) ? MAX_SERVOS : SLOT_LIMIT;

    localparam logic [1:0]  HDR_LEN   = 2'(HEADER_LEN);
    localparam logic [6:0]  CNT_LIMIT = 7'(COUNT_LIMIT);
    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [16:0] RAW_SPAN  = 17'd65535;

    // Register map, indexed by paddr[2].
    localparam logic REG_SERVO_COUNT = 1'b0;
    localparam logic REG_FULL_SCALE  = 1'b1;

    localparam logic [6:0]  SERVO_COUNT_RST = 7'd1;
    localparam logic [14:0] FULL_SCALE_RST  = 15'd25736;

    // Position of the next byte within a record.
    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    // One complete record on its way to the angle scaling pipeline.
    typedef struct packed {
        logic [5:0]  slot;
        logic [7:0]  servo_id;
        logic [15:0] raw;
        logic        last;
    } rec_t;

endpackage

// ===== rtl/core/servo_feedback_deframer.sv =====
// Servo feedback deframer. One received byte is taken per cycle on the rx
// channel, every cycle, until two finished records wait behind a stalled
// result. The block hunts for a header of consecutive 0xFF bytes and
// then splits the following bytes into 3-byte records (id, position low,
// position high); the third byte of each record yields one result transfer
// carrying the slot, id, raw position, a signed angle in units of 2^-13 rad
// and a last-record flag; after a frame's last record the block hunts again.
// Taking the third byte registers the record in stage 1, stage 2 then
// captures the 16 x 15 bit scaling multiply, and the result register
// loads the reduction by 65535. servo_count (address 0) sets the records
// per frame, clamped to 1..64, and full_scale (address 4) sets the angle at
// the ends of the raw range; write them only while no result is pending.
module servo_feedback_deframer (
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Received byte channel
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic [7:0]          rx_byte,
    // Result channel
    output logic                res_valid,
    input  logic                res_stall,
    output logic [5:0]          slot,
    output logic [7:0]          servo_id,
    output logic [15:0]         raw_position,
    output logic signed [15:0]  angle,
    output logic                frame_last
);
    import svfd_pkg::*;

    logic [6:0]  servo_count_reg;
    logic [14:0] full_scale_reg;

    logic [1:0]  header_reg;
    logic [1:0]  header_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [5:0]  slot_reg;
    logic [5:0]  slot_next;
    logic [7:0]  held_id_reg;
    logic [7:0]  held_id_next;
    logic [7:0]  held_low_reg;
    logic [7:0]  held_low_next;

    logic        rx_take;
    logic        hunting;
    logic [6:0]  eff_count;
    logic        last_now;
    logic        rec_valid;
    rec_t        rec;
    rec_t        res;
    logic        cfg_write;

    // Configuration registers; a write keeps only each register's width.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_count_reg <= SERVO_COUNT_RST;
            full_scale_reg  <= FULL_SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SERVO_COUNT: servo_count_reg <= pwdata[6:0];
                REG_FULL_SCALE:  full_scale_reg  <= pwdata[14:0];
                default:         servo_count_reg <= servo_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SERVO_COUNT: prdata = {25'b0, servo_count_reg};
            REG_FULL_SCALE:  prdata = {17'b0, full_scale_reg};
            default:         prdata = '0;
        endcase
    end

    // Records per frame in force: zero acts as one, large counts clamp.
    always_comb
    begin
        eff_count = servo_count_reg;
        if (eff_count == 7'd0)
        begin
            eff_count = 7'd1;
        end
        else if (eff_count > CNT_LIMIT)
        begin
            eff_count = CNT_LIMIT;
        end
    end

    assign rx_take  = rx_valid && !rx_stall;
    assign hunting  = header_reg < HDR_LEN;
    assign last_now = ({1'b0, slot_reg} + 7'd1) >= eff_count;

    // Next state of the header hunt and the record assembly.
    always_comb
    begin
        header_next   = header_reg;
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        held_id_next  = held_id_reg;
        held_low_next = held_low_reg;
        if (rx_take)
        begin
            if (hunting)
            begin
                phase_next  = PH_ID;
                slot_next   = '0;
                header_next = (rx_byte == SYNC_BYTE) ? (header_reg + 2'd1) : 2'd0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LOW:
                    begin
                        held_low_next = rx_byte;
                        phase_next    = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        phase_next = PH_ID;
                        if (last_now)
                        begin
                            slot_next   = '0;
                            header_next = 2'd0;
                        end
                        else
                        begin
                            slot_next = slot_reg + 6'd1;
                        end
                    end
                    default:
                    begin
                        held_id_next = rx_byte;
                        phase_next   = PH_LOW;
                    end
                endcase
            end
        end
    end

    // A record leaves on the transfer of its high position byte.
    always_comb
    begin
        rec_valid    = rx_take && !hunting && (phase_reg == PH_HIGH);
        rec.slot     = slot_reg;
        rec.servo_id = held_id_reg;
        rec.raw      = {rx_byte, held_low_reg};
        rec.last     = last_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= 2'd0;
            phase_reg    <= PH_ID;
            slot_reg     <= '0;
            held_id_reg  <= '0;
            held_low_reg <= '0;
        end
        else
        begin
            header_reg   <= header_next;
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            held_id_reg  <= held_id_next;
            held_low_reg <= held_low_next;
        end
    end

    // Angle scaling and result buffering.
    svfd_record_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .full_scale (full_scale_reg),
        .rec_valid  (rec_valid),
        .rec        (rec),
        .rec_stall  (rx_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .angle      (angle)
    );

    assign slot         = res.slot;
    assign servo_id     = res.servo_id;
    assign raw_position = res.raw;
    assign frame_last   = res.last;

endmodule

// ===== rtl/core/svfd_record_pipe.sv =====
module svfd_record_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [14:0]          full_scale,
    input  logic                 rec_valid,
    input  svfd_pkg::rec_t       rec,
    output logic                 rec_stall,
    output logic                 res_valid,
    input  logic                 res_stall,
    output svfd_pkg::rec_t       res,
    output logic signed [15:0]   angle
);
    import svfd_pkg::*;

    logic        s1_valid_reg;
    rec_t        s1_rec_reg;
    logic        s2_valid_reg;
    rec_t        s2_rec_reg;
    logic [30:0] s2_prod_reg;
    logic        s2_neg_reg;
    logic        out_valid_reg;
    rec_t        out_rec_reg;
    logic [15:0] out_angle_reg;

    logic        out_free;
    logic        s2_free;
    logic        s1_free;

    logic [16:0] twice_raw;
    logic        neg;
    logic [16:0] mag_wide;
    logic [30:0] prod_next;

    logic [31:0] sum;
    logic [15:0] q0;
    logic [31:0] rem;
    logic [15:0] quot;
    logic [15:0] angle_next;

    // Each stage moves on when the stage after it is empty or moving too.
    assign out_free  = !out_valid_reg || !res_stall;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign rec_stall = !s1_free;

    // Stage 1: magnitude of the centered position, times full scale.
    assign twice_raw = {s1_rec_reg.raw, 1'b0};
    assign neg       = ~s1_rec_reg.raw[15];
    assign mag_wide  = neg ? (RAW_SPAN - twice_raw) : (twice_raw - RAW_SPAN);
    assign prod_next = {15'b0, mag_wide[15:0]} * {16'b0, full_scale};

    // Stage 2: divide by 65535 through the reciprocal estimate, which is at
    // most one short, then fix it with one compare against the remainder.
    assign sum  = {1'b0, s2_prod_reg} + {17'b0, s2_prod_reg[30:16]};
    assign q0   = sum[31:16];
    assign rem  = {1'b0, s2_prod_reg} + {16'b0, q0} - {q0, 16'b0};
    assign quot = q0 + {15'b0, (rem >= {15'b0, RAW_SPAN})};
    assign angle_next = s2_neg_reg ? (16'd0 - quot) : quot;

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= rec_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_rec_reg <= rec;
        end
        if (s2_free)
        begin
            s2_rec_reg  <= s1_rec_reg;
            s2_prod_reg <= prod_next;
            s2_neg_reg  <= neg;
        end
        if (out_free)
        begin
            out_rec_reg   <= s2_rec_reg;
            out_angle_reg <= angle_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_rec_reg;
    assign angle     = out_angle_reg;

endmodule

// ===== rtl/core/svfd_checker.sv =====
module svfd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  logic                res_stall,
    input  logic [5:0]          slot,
    input  logic [7:0]          servo_id,
    input  logic [15:0]         raw_position,
    input  logic signed [15:0]  angle,
    input  logic                frame_last
);

    logic [5:0] exp_slot_reg;
    logic       res_done;

    assign res_done = res_valid && !res_stall;

    // Slot expected on the next result: counts up within a frame, then zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_slot_reg <= '0;
        end
        else if (res_done)
        begin
            exp_slot_reg <= frame_last ? 6'd0 : (slot + 6'd1);
        end
    end

    // A stalled result holds its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(slot) && $stable(servo_id)
            && $stable(raw_position) && $stable(angle) && $stable(frame_last))
        else $error("stalled result changed");

    // Records within a frame come out in slot order.
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> slot == exp_slot_reg)
        else $error("result slot out of sequence");

    // Positions below mid-range give angles at or below zero.
    a_low_sign: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !raw_position[15] |-> angle[15] || angle == 16'sd0)
        else $error("angle sign wrong for lower half of range");

    // Positions at or above mid-range give angles at or above zero.
    a_high_sign: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && raw_position[15] |-> !angle[15])
        else $error("angle sign wrong for upper half of range");

endmodule

bind servo_feedback_deframer svfd_checker u_svfd_checker (.*);

// ===== tb/tb_servo_feedback_deframer.sv =====
`timescale 1ns / 100ps

module tb_servo_feedback_deframer;

    import svfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DIR_ROWS    = 27;
    localparam int NUM_PHASES  = 6;

    localparam logic [2:0]  ADDR_SERVO_COUNT = {REG_SERVO_COUNT, 2'b00};
    localparam logic [2:0]  ADDR_FULL_SCALE  = {REG_FULL_SCALE, 2'b00};
    localparam logic [31:0] SERVO_COUNT_MASK = 32'h0000_007F;
    localparam logic [31:0] FULL_SCALE_MASK  = 32'h0000_7FFF;

    // One decoded servo record as it leaves the block.
    typedef struct packed {
        logic [5:0]         slot;
        logic [7:0]         id;
        logic [15:0]        raw;
        logic signed [15:0] ang;
        logic               last;
    } servo_rec_t;

    // One row of the directed byte stream, with an optional hand-written record.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        servo_rec_t rec;
    } byte_row_t;

    localparam servo_rec_t NO_REC = '0;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               rx_valid = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic [5:0]         slot;
    logic [7:0]         servo_id;
    logic [15:0]        raw_position;
    logic signed [15:0] angle;
    logic               frame_last;

    servo_feedback_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .slot         (slot),
        .servo_id     (servo_id),
        .raw_position (raw_position),
        .angle        (angle),
        .frame_last   (frame_last)
    );

    // Deframer state and register copies kept by the testbench.
    logic [1:0]  hdr_cnt;
    phase_t      rec_phase;
    logic [5:0]  cur_slot;
    logic [7:0]  id_hold;
    logic [7:0]  low_hold;
    logic [6:0]  cfg_servo_count;
    logic [14:0] cfg_full_scale;

    servo_rec_t  pending_records[$];
    logic [7:0]  byte_stream[$];
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;

    byte_row_t   dir_rows [DIR_ROWS];
    int          phase_count [NUM_PHASES];
    int          phase_scale [NUM_PHASES];
    int          phase_items [NUM_PHASES];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Records per frame after the zero and upper clamps.
    function automatic logic [6:0] frame_records();
        logic [6:0] n;
        n = cfg_servo_count;
        if (n == 7'd0)
            n = 7'd1;
        if (n > CNT_LIMIT)
            n = CNT_LIMIT;
        return n;
    endfunction

    // Advance the deframer by one byte; returns 1 when a record completes.
    function automatic bit deframe_step(input logic [7:0] b, output servo_rec_t r);
        logic [15:0] raw;
        longint      centered;
        longint      q;
        logic        last;
        r = NO_REC;
        if (hdr_cnt < HDR_LEN)
        begin
            rec_phase = PH_ID;
            cur_slot = '0;
            hdr_cnt = (b == SYNC_BYTE) ? hdr_cnt + 2'd1 : 2'd0;
            return 1'b0;
        end
        if (rec_phase == PH_LOW)
        begin
            low_hold = b;
            rec_phase = PH_HIGH;
            return 1'b0;
        end
        if (rec_phase != PH_HIGH)
        begin
            id_hold = b;
            rec_phase = PH_LOW;
            return 1'b0;
        end
        // Third byte: build the position and scale it, truncating toward zero.
        raw = {b, low_hold};
        last = (7'(cur_slot) + 7'd1) >= frame_records();
        centered = 2 * longint'(raw) - longint'(RAW_SPAN);
        q = (centered * longint'(cfg_full_scale)) / longint'(RAW_SPAN);
        r = '{cur_slot, id_hold, raw, q[15:0], last};
        rec_phase = PH_ID;
        if (last)
        begin
            cur_slot = '0;
            hdr_cnt = 2'd0;
        end
        else
        begin
            cur_slot = cur_slot + 6'd1;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s", msg);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Read both registers back and compare with the expected values.
    task automatic verify_regs();
        logic [31:0] rd;
        apb_access(ADDR_SERVO_COUNT, 1'b0, '0, rd);
        if (rd !== 32'(cfg_servo_count))
            report_mismatch($sformatf("servo_count readback: expected %0d got %0d",
                                      cfg_servo_count, rd));
        apb_access(ADDR_FULL_SCALE, 1'b0, '0, rd);
        if (rd !== 32'(cfg_full_scale))
            report_mismatch($sformatf("full_scale readback: expected %0d got %0d",
                                      cfg_full_scale, rd));
    endtask

    // Write both registers with junk in the bits above their width.
    task automatic write_config(input int count_val, input int scale_val);
        logic [31:0] wd;
        logic [31:0] rd;
        wd = ($urandom() & ~SERVO_COUNT_MASK) | (32'(count_val) & SERVO_COUNT_MASK);
        apb_access(ADDR_SERVO_COUNT, 1'b1, wd, rd);
        cfg_servo_count = wd[6:0];
        wd = ($urandom() & ~FULL_SCALE_MASK) | (32'(scale_val) & FULL_SCALE_MASK);
        apb_access(ADDR_FULL_SCALE, 1'b1, wd, rd);
        cfg_full_scale = wd[14:0];
        verify_regs();
    endtask

    // Offer one byte, with random gaps between bursts, and predict its result.
    task automatic send_byte(input logic [7:0] b, input logic typed, input servo_rec_t typed_rec);
        servo_rec_t r;
        int         gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                rx_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (rx_stall === 1'b1);
        if (deframe_step(b, r))
            pending_records.push_back(typed ? typed_rec : r);
    endtask

    // Queue one frame: optional noise, the sync header, then full records.
    task automatic queue_frame();
        int          noise;
        logic [15:0] pos;
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        for (int k = 0; k < noise; k++)
        begin
            if (k < noise - 1 && $urandom_range(0, 1) == 1)
                byte_stream.push_back(SYNC_BYTE);
            else
                byte_stream.push_back(8'($urandom_range(0, 254)));
        end
        repeat (HEADER_LEN) byte_stream.push_back(SYNC_BYTE);
        for (int k = 0; k < int'(frame_records()); k++)
        begin
            if ($urandom_range(0, 7) == 0)
                pos = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            else
                pos = 16'($urandom());
            byte_stream.push_back(8'($urandom_range(0, 255)));
            byte_stream.push_back(pos[7:0]);
            byte_stream.push_back(pos[15:8]);
        end
    endtask

    // Stop offering bytes and wait until every expected record has left.
    task automatic drain_pipe();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Result stall pattern: free, random, solid and alternating stretches.
    initial
    begin
        int   mode;
        int   len;
        logic alt;
        alt = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(8, 60);
            repeat (len)
            begin
                @(negedge clk);
                alt = ~alt;
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 2) == 0);
                    2: res_stall <= 1'b1;
                    default: res_stall <= alt;
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest expected record.
    always @(posedge clk)
    begin
        servo_rec_t got;
        servo_rec_t want;
        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            got = '{slot, servo_id, raw_position, angle, frame_last};
            if (pending_records.size() == 0)
            begin
                report_mismatch($sformatf(
                    "unexpected record: slot=%0d id=%02h raw=%04h angle=%0d last=%0b",
                    got.slot, got.id, got.raw, got.ang, got.last));
            end
            else
            begin
                want = pending_records.pop_front();
                if (got !== want)
                    report_mismatch($sformatf({"record mismatch: expected slot=%0d id=%02h ",
                        "raw=%04h angle=%0d last=%0b, got slot=%0d id=%02h raw=%04h ",
                        "angle=%0d last=%0b"},
                        want.slot, want.id, want.raw, want.ang, want.last,
                        got.slot, got.id, got.raw, got.ang, got.last));
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        hdr_cnt = 2'd0;
        rec_phase = PH_ID;
        cur_slot = '0;
        id_hold = '0;
        low_hold = '0;
        cfg_servo_count = SERVO_COUNT_RST;
        cfg_full_scale = FULL_SCALE_RST;

        // Reset-default registers: one record per frame, full scale of about pi.
        dir_rows = '{
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'h00, 1'b0, NO_REC},
            '{8'h00, 1'b0, NO_REC},
            '{8'h00, 1'b1, '{6'd0, 8'h00, 16'h0000, -16'sd25736, 1'b1}},
            // A third sync byte after a full header is the record id.
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b1, '{6'd0, 8'hFF, 16'hFFFF, 16'sd25736, 1'b1}},
            // A broken header starts the hunt over.
            '{8'hFF, 1'b0, NO_REC},
            '{8'h12, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'h5A, 1'b0, NO_REC},
            '{8'h00, 1'b0, NO_REC},
            '{8'h80, 1'b1, '{6'd0, 8'h5A, 16'h8000, 16'sd0, 1'b1}},
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'hA5, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'h7F, 1'b1, '{6'd0, 8'hA5, 16'h7FFF, 16'sd0, 1'b1}},
            '{8'hFF, 1'b0, NO_REC},
            '{8'hFF, 1'b0, NO_REC},
            '{8'h3C, 1'b0, NO_REC},
            '{8'h34, 1'b0, NO_REC},
            '{8'h12, 1'b0, NO_REC}
        };

        // Register settings per phase; phases cut frames at arbitrary points.
        phase_count = '{0, 3, 64, 127, $urandom_range(2, 8), 1};
        phase_scale = '{32767, 0, $urandom_range(0, 32767), 32767, $urandom_range(0, 32767), 1};
        phase_items = '{110, 110, 220, 220, 110, 105};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        verify_regs();

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].rec);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_pipe();
            write_config(phase_count[p], phase_scale[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (byte_stream.size() == 0)
                    queue_frame();
                send_byte(byte_stream.pop_front(), 1'b0, NO_REC);
            end
        end

        drain_pipe();
        if (mismatch_cnt == 0 && pending_records.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
